/* rtl/core/idsp_pkg.sv */
package idsp_pkg;

   // Request codes
   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_WAKE     = 3'd1;
   localparam logic [2:0] REQ_ACTIVITY = 3'd2;
   localparam logic [2:0] REQ_MODE     = 3'd3;
   localparam logic [2:0] REQ_SHUTDOWN = 3'd4;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_DEEP_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_SETTLE       = 2'd2;

   // Sensor profile codes
   localparam logic [1:0] PROFILE_BALL = 2'd0;
   localparam logic [1:0] PROFILE_AIR  = 2'd1;
   localparam logic [1:0] PROFILE_IDLE = 2'd2;

   // Register reset values
   localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd60000;
   localparam logic [31:0] DEEP_TIMEOUT_RESET = 32'd1800000;
   localparam logic [15:0] SETTLE_RESET       = 16'd50;

   // Register set seen by the state unit
   typedef struct packed {
      logic [31:0] idle_timeout_ticks;
      logic [31:0] deep_timeout_ticks;
      logic [15:0] settle_ticks;
   } idsp_cfg_type;

   // One result beat
   typedef struct packed {
      logic       system_off;
      logic       idle_sleep;
      logic       ir_enable;
      logic [1:0] sensor_profile;
      logic       report_permit;
      logic       entered_idle;
      logic       woke_from_idle;
   } idsp_rsp_type;

endpackage

/* rtl/core/idsp_state.sv */
module idsp_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_accept,
   input  logic [2:0]            req_type,
   input  logic                  wake_from_imu,
   input  logic                  ball_mode,
   input  logic                  usb_host,
   input  idsp_pkg::idsp_cfg_type cfg,
   output idsp_pkg::idsp_rsp_type result
);
   import idsp_pkg::*;

   logic [31:0] idle_count_ff, idle_count_in;
   logic [31:0] deep_count_ff, deep_count_in;
   logic [15:0] settle_count_ff, settle_count_in;
   logic        is_idle_ff, is_idle_in;
   logic        ir_allowed_ff, ir_allowed_in;
   logic        has_woken_ff, has_woken_in;
   logic        is_off_ff, is_off_in;
   logic        entered;
   logic        woke;
   logic [31:0] idle_inc;
   logic [31:0] deep_inc;

   // Saturating increments
   assign idle_inc = (idle_count_ff == '1) ? idle_count_ff : idle_count_ff + 32'd1;
   assign deep_inc = (deep_count_ff == '1) ? deep_count_ff : deep_count_ff + 32'd1;

   // Next state for one beat
   always_comb begin
      idle_count_in   = idle_count_ff;
      deep_count_in   = deep_count_ff;
      settle_count_in = settle_count_ff;
      is_idle_in      = is_idle_ff;
      ir_allowed_in   = ir_allowed_ff;
      has_woken_in    = has_woken_ff;
      is_off_in       = is_off_ff;
      entered         = 1'b0;
      woke            = 1'b0;
      if (!is_off_ff) begin
         case (req_type)
            REQ_TICK: begin
               if (settle_count_ff != '1) begin
                  settle_count_in = settle_count_ff + 16'd1;
               end
               if (usb_host) begin
                  if (is_idle_ff) begin
                     is_idle_in      = 1'b0;
                     has_woken_in    = 1'b1;
                     settle_count_in = '0;
                     woke            = 1'b1;
                  end
                  idle_count_in = '0;
                  deep_count_in = '0;
               end else begin
                  idle_count_in = idle_inc;
                  deep_count_in = deep_inc;
                  if (deep_inc > cfg.deep_timeout_ticks) begin
                     is_off_in = 1'b1;
                  end else if (idle_inc > cfg.idle_timeout_ticks && !is_idle_ff) begin
                     is_idle_in = 1'b1;
                     entered    = 1'b1;
                  end
               end
            end
            REQ_WAKE: begin
               if (is_idle_ff) begin
                  is_idle_in      = 1'b0;
                  has_woken_in    = 1'b1;
                  settle_count_in = '0;
                  woke            = 1'b1;
               end
               idle_count_in = '0;
               // IMU motion while idle does not postpone deep sleep
               if (!(is_idle_ff && wake_from_imu)) begin
                  deep_count_in = '0;
               end
            end
            REQ_ACTIVITY: begin
               idle_count_in = '0;
               deep_count_in = '0;
            end
            REQ_MODE: begin
               ir_allowed_in = ball_mode;
            end
            REQ_SHUTDOWN: begin
               is_off_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Status after the beat
   always_comb begin
      result.system_off     = is_off_in;
      result.idle_sleep     = is_idle_in;
      result.ir_enable      = !is_off_in && !is_idle_in && ir_allowed_in;
      result.sensor_profile = is_idle_in ? PROFILE_IDLE :
                              (ir_allowed_in ? PROFILE_BALL : PROFILE_AIR);
      result.report_permit  = !is_off_in && !is_idle_in &&
                              (!has_woken_in || settle_count_in >= cfg.settle_ticks);
      result.entered_idle   = entered && !is_off_in;
      result.woke_from_idle = woke && !is_off_in;
   end

   // Advance state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_count_ff   <= '0;
         deep_count_ff   <= '0;
         settle_count_ff <= '0;
         is_idle_ff      <= 1'b0;
         ir_allowed_ff   <= 1'b1;
         has_woken_ff    <= 1'b0;
         is_off_ff       <= 1'b0;
      end else if (item_accept) begin
         idle_count_ff   <= idle_count_in;
         deep_count_ff   <= deep_count_in;
         settle_count_ff <= settle_count_in;
         is_idle_ff      <= is_idle_in;
         ir_allowed_ff   <= ir_allowed_in;
         has_woken_ff    <= has_woken_in;
         is_off_ff       <= is_off_in;
      end
   end

   a_off_sticky: assert property (@(posedge clock) disable iff (reset)
      is_off_ff |=> is_off_ff)
      else $error("off state left without reset");

   a_usb_clears: assert property (@(posedge clock) disable iff (reset)
      (item_accept && !is_off_ff && req_type == REQ_TICK && usb_host)
      |=> (idle_count_ff == '0 && deep_count_ff == '0 && !is_idle_ff))
      else $error("usb host tick did not clear counters");

   a_pulses_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(result.entered_idle && result.woke_from_idle))
      else $error("enter and wake pulses on one beat");

   a_off_freezes: assert property (@(posedge clock) disable iff (reset)
      is_off_ff |=> ($stable(idle_count_ff) && $stable(is_idle_ff)
                     && $stable(ir_allowed_ff)))
      else $error("state moved while off");

endmodule

/* rtl/core/idsp_rsp.sv */
module idsp_rsp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  idsp_pkg::idsp_rsp_type result,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   room,
   output idsp_pkg::idsp_rsp_type rsp_beat
);
   import idsp_pkg::*;

   logic         valid_ff, valid_in;
   idsp_rsp_type beat_ff;

   // Free when empty or being drained this cycle
   assign room     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the beat until it is taken
   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !load)
      else $error("pending result overwritten");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_off_quiet: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && beat_ff.system_off) |-> (!beat_ff.ir_enable && !beat_ff.report_permit))
      else $error("off result with outputs active");

endmodule

/* rtl/core/idle_deep_sleep_power_controller.sv */
// Power-mode controller for a battery mouse. Each request beat (tick, wake,
// activity, mode or shutdown) returns exactly one response beat with the
// status after that request. One request is taken per clock cycle: the
// state update is a single combinational pass into one response register,
// so a beat is accepted whenever that register is empty or is being drained
// in the same cycle, and its response appears on the next cycle. req_stall
// follows rsp_stall combinationally while a response is pending. The csr
// port is always ready; a register write takes effect from the next cycle.
// Index 0 is the idle timeout, 1 the deep-sleep timeout, 2 the settle time;
// other indexes are ignored.
module idle_deep_sleep_power_controller (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic        req_wake_from_imu,
   input  logic        req_ball_mode,
   input  logic        req_usb_host,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_system_off,
   output logic        rsp_idle_sleep,
   output logic        rsp_ir_enable,
   output logic [1:0]  rsp_sensor_profile,
   output logic        rsp_report_permit,
   output logic        rsp_entered_idle,
   output logic        rsp_woke_from_idle,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import idsp_pkg::*;

   idsp_cfg_type cfg_ff;
   idsp_rsp_type result;
   idsp_rsp_type rsp_beat;
   logic         room;
   logic         item_accept;

   assign csr_ready   = 1'b1;
   assign req_stall   = !room;
   assign item_accept = req_valid && room;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout_ticks <= IDLE_TIMEOUT_RESET;
         cfg_ff.deep_timeout_ticks <= DEEP_TIMEOUT_RESET;
         cfg_ff.settle_ticks       <= SETTLE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IDLE_TIMEOUT: cfg_ff.idle_timeout_ticks <= csr_data;
            CSR_DEEP_TIMEOUT: cfg_ff.deep_timeout_ticks <= csr_data;
            CSR_SETTLE:       cfg_ff.settle_ticks       <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   idsp_state u_state (
      .clock         (clock),
      .reset         (reset),
      .item_accept   (item_accept),
      .req_type      (req_type),
      .wake_from_imu (req_wake_from_imu),
      .ball_mode     (req_ball_mode),
      .usb_host      (req_usb_host),
      .cfg           (cfg_ff),
      .result        (result)
   );

   idsp_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (item_accept),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .room      (room),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_system_off     = rsp_beat.system_off;
   assign rsp_idle_sleep     = rsp_beat.idle_sleep;
   assign rsp_ir_enable      = rsp_beat.ir_enable;
   assign rsp_sensor_profile = rsp_beat.sensor_profile;
   assign rsp_report_permit  = rsp_beat.report_permit;
   assign rsp_entered_idle   = rsp_beat.entered_idle;
   assign rsp_woke_from_idle = rsp_beat.woke_from_idle;

endmodule
